@@ rtl/sha_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    // One classified beat passed from the front to the core.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } sha_cmd_t;

    localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

@@ rtl/sha256_hash_stream_top.sv @@
// Top level of the streaming SHA-256 hasher.
//
//  channel  dir  beat contents
//  s_*      in   tdata: data_byte[7:0]; tuser: has_byte; tlast: last_item
//  m_*      out  tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast: last_word
//
// The core takes queued byte beats one at a time while idle; each full block runs 64 rounds
// on the single shared round unit, then a hash update.
// The end of a message adds a pad step, zero fill, a length step
// and one or two compressions.
// Reset is asynchronous, active low, and restores the initial hash values.
// A four-entry queue decouples the input from the core; digest words hold under stall.
`timescale 1ns / 1ps
module sha256_hash_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast
);
    import sha_pkg::*;

    sha_cmd_t q_data;
    logic     q_valid, q_ready;

    sha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule

@@ rtl/sha_fifo.sv @@
// Short queue of classified beats between the front and the hash core.
`timescale 1ns / 1ps
module sha_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  sha_pkg::sha_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output sha_pkg::sha_cmd_t rd_data
);
    import sha_pkg::*;

    sha_cmd_t   mem_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule

@@ rtl/sha_front.sv @@
// Front end: takes input beats, drops empty ones and queues the rest.
`timescale 1ns / 1ps
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              s_tlast,
    output logic              q_valid,
    input  logic              q_ready,
    output sha_pkg::sha_cmd_t q_data
);
    import sha_pkg::*;

    sha_cmd_t cmd;
    logic     useful;
    logic     wr_ready;

    // A beat with neither a byte nor an end mark does nothing.
    assign useful         = s_tuser || s_tlast;
    assign cmd.data_byte  = s_tdata;
    assign cmd.has_byte   = s_tuser;
    assign cmd.last_item  = s_tlast;
    assign s_tready       = wr_ready;

    sha_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid && useful),
        .wr_ready (wr_ready),
        .wr_data  (cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );
endmodule

@@ rtl/sha_core.sv @@
// Hash core: block buffer, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sha_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  sha_pkg::sha_cmd_t q_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_ADD, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] w_reg [BLOCK_WORDS];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        fin_reg;
    logic        last_comp_reg;
    logic        extra_reg;

    logic [31:0] w_new, w_cur, t1, t2;
    logic [31:0] wr_word;
    logic [31:0] h_sum [8];

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = h_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 3'd7);

    // Message schedule from a 16-word sliding window; round word is the head.
    assign w_cur = w_reg[0];
    assign w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + big1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg] + w_cur;
    assign t2 = big0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i] = h_reg[i] + v_reg[i];
        end
    end

    // Byte lane insert into the word held at fill position.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (lane)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

    assign wr_word = put_byte(w_reg[fill_reg[5:2]], fill_reg[1:0],
                              (state_reg == ST_IDLE) ? q_data.data_byte : 8'h00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            fin_reg       <= 1'b0;
            last_comp_reg <= 1'b0;
            extra_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= START_H[i];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                // Take one queued beat: store byte, compress a full block, and start padding on the end mark.
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        fin_reg <= q_data.last_item;
                        if (q_data.has_byte)
                        begin
                            w_reg[fill_reg[5:2]] <= wr_word;
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                            if (fill_reg == 6'(BLOCK_BYTES - 1))
                            begin
                                last_comp_reg <= 1'b0;
                                round_reg     <= '0;
                                for (int i = 0; i < 8; i++)
                                begin
                                    v_reg[i] <= h_reg[i];
                                end
                                state_reg <= ST_COMP;
                            end
                            else if (q_data.last_item)
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                // Place the 0x80 mark; a mark in the last byte fills the block.
                ST_PAD:
                begin
                    w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]], fill_reg[1:0],
                                                     PAD_MARK);
                    fill_reg  <= fill_reg + 6'd1;
                    fin_reg   <= 1'b0;
                    if (fill_reg == 6'(BLOCK_BYTES - 1))
                    begin
                        extra_reg     <= 1'b1;
                        last_comp_reg <= 1'b0;
                        round_reg     <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                        state_reg <= ST_COMP;
                    end
                    else
                    begin
                        state_reg <= ST_LEN;
                    end
                end
                // Zero fill one byte a cycle, then length or an extra block.
                ST_LEN:
                begin
                    if (fill_reg > 6'(LEN_POS))
                    begin
                        w_reg[fill_reg[5:2]] <= wr_word;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            // Block is filled up with pad: compress it, length block follows.
                            extra_reg     <= 1'b1;
                            last_comp_reg <= 1'b0;
                            round_reg     <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                            state_reg <= ST_COMP;
                        end
                    end
                    else if (fill_reg < 6'(LEN_POS))
                    begin
                        w_reg[fill_reg[5:2]] <= wr_word;
                        fill_reg <= fill_reg + 6'd1;
                    end
                    else
                    begin
                        w_reg[14]     <= len_reg[63:32];
                        w_reg[15]     <= len_reg[31:0];
                        last_comp_reg <= 1'b1;
                        round_reg     <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                        state_reg <= ST_COMP;
                    end
                end
                // One round per cycle; the window shifts with each round.
                ST_COMP:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[BLOCK_WORDS - 1] <= w_new;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(NUM_ROUNDS - 1))
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                // Fold the working words into the hash.
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_sum[i];
                    end
                    fill_reg <= '0;
                    if (last_comp_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (fin_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else if (extra_reg)
                    begin
                        // Padded block done; the length block follows.
                        extra_reg <= 1'b0;
                        state_reg <= ST_LEN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                // Hand out eight digest words, then restart.
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= START_H[i];
                            end
                            len_reg       <= '0;
                            fill_reg      <= '0;
                            last_comp_reg <= 1'b0;
                            extra_reg     <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

@@ rtl/sha_checker.sv @@
// Port checker for the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    // The last word flag marks index seven only.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("last word flag does not match index");

    // Digest words come out in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of order");

    // A stalled word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled digest word changed");

    // No output right after a completed digest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output after last word");
endmodule

bind sha256_hash_stream_top sha_checker u_sha_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/tb.sv @@
// Self-checking testbench for the streaming SHA-256 hasher.
`timescale 1ns / 1ps
module tb;
    import sha_pkg::*;

    // Expected digest beat.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // Tracks the message state and holds the digest words still owed.
    class digest_scoreboard;
        logic [31:0]  hash_state [8];
        logic [7:0]   msg_block [64];
        int unsigned  fill;
        logic [63:0]  bit_count;
        digest_beat_t pending [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hash_state[i] = START_H[i];
            fill = 0;
            bit_count = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One 64-round compression of the gathered block.
        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2, ch, mj;
            for (int r = 0; r < 16; r++)
                w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
            for (int r = 16; r < 64; r++)
            begin
                s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = hash_state[i];
            for (int r = 0; r < 64; r++)
            begin
                s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1 = v[7] + s1 + ch + ROUND_K[r] + w[r];
                s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t2 = s0 + mj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_state[i] += v[i];
        endfunction

        // Notes one accepted input beat.
        function void note_input(logic [7:0] data, logic has, logic last);
            digest_beat_t b;
            if (has)
            begin
                msg_block[fill] = data;
                fill++;
                bit_count += 64'd8;
                if (fill == 64)
                begin
                    compress_block();
                    fill = 0;
                end
            end
            if (last)
            begin
                msg_block[fill] = PAD_MARK;
                fill++;
                if (fill > LEN_POS)
                begin
                    while (fill < 64) msg_block[fill++] = 8'h00;
                    compress_block();
                    fill = 0;
                end
                while (fill < LEN_POS) msg_block[fill++] = 8'h00;
                for (int i = 0; i < 8; i++) msg_block[63-i] = bit_count[8*i +: 8];
                compress_block();
                for (int i = 0; i < 8; i++)
                begin
                    b.word = hash_state[i];
                    b.index = i[2:0];
                    b.last = (i == 7);
                    pending.push_back(b);
                end
                restart();
            end
        endfunction

        // Checks one accepted digest beat against the oldest expectation.
        function void check_digest(logic [31:0] word, logic [2:0] index, logic last);
            digest_beat_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected digest beat %h", word);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (word !== e.word)
            begin
                $error("digest_word expected %h actual %h", e.word, word);
                errors++;
            end
            if (index !== e.index)
            begin
                $error("word_index expected %0d actual %0d", e.index, index);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_word expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic        s_tuser;   // has_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // digest_word[31:0]
    logic [2:0]  m_tuser;   // word_index[2:0]
    logic        m_tlast;

    digest_scoreboard sb;
    int unsigned      cycle_count;
    int unsigned      hold_off;
    int unsigned      gap_left;

    sha256_hash_stream_top dut (.*);

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000)
        begin
            $display("sha256_hash_stream_top regression: fail");
            $finish;
        end
    end

    // Checks each accepted digest beat.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_digest(m_tdata, m_tuser, m_tlast);

    // Receiver stalls: a long hold-off when requested, else ready in periodic windows and random between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off != 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (cycle_count % 2000 < 500)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(3) != 0);
    end

    // Sends one beat in bursts with random gaps between them.
    task automatic send_beat(input logic [7:0] data, input logic has, input logic last);
        if (gap_left == 0 && $urandom_range(7) == 0)
            gap_left = $urandom_range(6);
        while (gap_left != 0)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(data, has, last);
    endtask

    // Sends a message of random bytes, optionally with empty beats mixed in.
    task automatic send_message(input int unsigned len, input bit noisy);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(5) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, 1'b0);
        end
        if ($urandom_range(1))
            send_beat(8'($urandom), 1'b0, 1'b1);
        else
            send_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    // Waits until every digest word owed has been accepted.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        hold_off = 0;
        gap_left = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, then an empty beat and a byte before a byte with last set.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        // A one-byte message, then lengths at the padding borders: 54 or 55, 55 or 56, and 63 or 64 bytes.
        send_beat(8'h61, 1'b1, 1'b1);
        drain();
        send_message(54, 1'b0);
        send_message(55, 1'b0);
        send_message(63, 1'b0);

        // Long receiver hold-off while the sender keeps offering.
        drain();
        hold_off = 400;
        send_message(3, 1'b0);
        send_message(70, 1'b1);
        send_message(0, 1'b0);
        drain();

        // Random messages, mostly short, a few spanning blocks.
        for (int n = 0; n < 7; n++)
        begin
            if ($urandom_range(4) == 0)
                send_message($urandom_range(140), 1'b1);
            else
                send_message($urandom_range(12), 1'b1);
            if ($urandom_range(9) == 0)
                drain();
        end
        drain();

        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sha256_hash_stream_top regression: pass");
        else
            $display("sha256_hash_stream_top regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/sha_pkg.sv
rtl/sha_fifo.sv
rtl/sha_front.sv
rtl/sha_core.sv
rtl/sha256_hash_stream_top.sv
rtl/sha_checker.sv
tb/tb.sv
